### hdl/jpv_pkg.sv
// jpv_pkg: types, codes and sizes shared by the jailed path validator
// no dependencies; used by the interfaces, the step logic and the top level
package jpv_pkg;

    localparam int PATH_MAX_BYTES   = 256;
    localparam int PREFIX_MAX_BYTES = 8;

    // byte index must reach PATH_MAX_BYTES after a pending dot-dot segment
    localparam int IDX_W = $clog2(PATH_MAX_BYTES + 1);
    localparam int MAXLEN_W = 9;
    localparam int PLEN_W = 4;
    localparam int PTEXT_W = 64;
    localparam int LEN_W = 9;
    localparam int CMP_W = ((IDX_W > MAXLEN_W) ? IDX_W : MAXLEN_W) + 1;
    localparam int CFG_ADDR_W = 2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_DENIED = 2'd1;
    localparam logic [1:0] ST_NOSPC  = 2'd2;

    localparam logic [1:0] SEG_START  = 2'd0;
    localparam logic [1:0] SEG_DOT    = 2'd1;
    localparam logic [1:0] SEG_DOTDOT = 2'd2;
    localparam logic [1:0] SEG_OTHER  = 2'd3;

    localparam logic [CFG_ADDR_W-1:0] REG_PREFIX_TEXT   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PREFIX_LENGTH = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_LENGTH    = 2'd2;

    localparam logic [7:0] CHAR_SLASH     = 8'h2f;
    localparam logic [7:0] CHAR_DOT       = 8'h2e;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;

    typedef struct packed {
        logic [PTEXT_W-1:0]  prefix_text;
        logic [PLEN_W-1:0]   prefix_length;
        logic [MAXLEN_W-1:0] max_length;
    } jpv_cfg_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [1:0]       seg;
        logic             pend_nospc;
        logic [1:0]       status;
        logic             pmatch;
    } jpv_state_t;

    localparam jpv_state_t STATE_CLEAR = '{
        idx:        '0,
        seg:        SEG_START,
        pend_nospc: 1'b0,
        status:     ST_OK,
        pmatch:     1'b1
    };

endpackage

### hdl/jpv_if.sv
// jpv_if: valid/ready channel interfaces for path bytes, results and register writes
// depends on jpv_pkg
interface jpv_path_if
    import jpv_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [7:0] path_byte;
    logic       last;

    modport source (output valid, output path_byte, output last, input ready);
    modport sink (input valid, input path_byte, input last, output ready);
endinterface

interface jpv_result_if
    import jpv_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [LEN_W-1:0] path_length;

    modport source (output valid, output status, output path_length, input ready);
    modport sink (input valid, input status, input path_length, output ready);
endinterface

interface jpv_cfg_if
    import jpv_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] index;
    logic [PTEXT_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/jpv_step.sv
// jpv_step: per-byte check, next path state and result word
// depends on jpv_pkg; purely combinational, used by jailed_path_validator
module jpv_step
    import jpv_pkg::*;
(
    input  jpv_cfg_t         cfg_val,
    input  jpv_state_t       st,
    input  logic [7:0]       c,
    input  logic             last,
    output jpv_state_t       st_next,
    output logic [1:0]       res_status,
    output logic [LEN_W-1:0] res_length
);

    logic [CMP_W-1:0]  limit;
    logic [PLEN_W-1:0] plen;
    logic [CMP_W-1:0]  idx_plus1;
    logic              nospc;
    logic              is_slash;
    logic              dot_after_dot;
    logic [7:0]        want;
    logic [1:0]        chk;
    jpv_state_t        upd;

    always_comb
    begin
        if (CMP_W'(cfg_val.max_length) > CMP_W'(PATH_MAX_BYTES))
        begin
            limit = CMP_W'(PATH_MAX_BYTES);
        end
        else
        begin
            limit = CMP_W'(cfg_val.max_length);
        end
        if (cfg_val.prefix_length > PLEN_W'(PREFIX_MAX_BYTES))
        begin
            plen = PLEN_W'(PREFIX_MAX_BYTES);
        end
        else
        begin
            plen = cfg_val.prefix_length;
        end
    end

    assign idx_plus1     = CMP_W'(st.idx) + CMP_W'(1);
    assign nospc         = idx_plus1 >= limit;
    assign is_slash      = c == CHAR_SLASH;
    assign dot_after_dot = (st.seg == SEG_DOT) && (c == CHAR_DOT);
    assign want          = cfg_val.prefix_text[st.idx[2:0]*8 +: 8];

    always_comb
    begin
        upd = st;
        chk = ST_OK;
        priority if (cfg_val.max_length < MAXLEN_W'(2))
        begin
            chk = ST_DENIED;
        end
        else if ((st.idx == '0) && !is_slash)
        begin
            chk = ST_DENIED;
        end
        else if ((st.seg == SEG_DOTDOT) && is_slash)
        begin
            chk = ST_DENIED;
        end
        else if ((st.seg == SEG_DOTDOT) && st.pend_nospc)
        begin
            chk = ST_NOSPC;
        end
        else if ((c == CHAR_BACKSLASH) || (c < CHAR_SPACE))
        begin
            chk = ST_DENIED;
        end
        else if (is_slash && nospc)
        begin
            chk = ST_NOSPC;
        end
        else if (is_slash && (st.seg == SEG_START) && (st.idx != '0))
        begin
            chk = ST_DENIED;
        end
        else if (!is_slash && !dot_after_dot && nospc)
        begin
            chk = ST_NOSPC;
        end
        else if (dot_after_dot && last)
        begin
            chk = ST_DENIED;
        end
        else
        begin
            if (is_slash)
            begin
                upd.seg = SEG_START;
            end
            else if (dot_after_dot)
            begin
                upd.seg = SEG_DOTDOT;
                upd.pend_nospc = nospc;
            end
            else if ((st.seg == SEG_START) && (c == CHAR_DOT))
            begin
                upd.seg = SEG_DOT;
            end
            else
            begin
                upd.seg = SEG_OTHER;
            end

            // prefix bytes, then the separator right after the prefix
            if (CMP_W'(st.idx) < CMP_W'(plen))
            begin
                upd.pmatch = st.pmatch && (c == want);
            end
            else if (CMP_W'(st.idx) == CMP_W'(plen))
            begin
                upd.pmatch = st.pmatch && is_slash;
            end

            if (last && ((idx_plus1 < CMP_W'(plen)) || !upd.pmatch))
            begin
                chk = ST_DENIED;
            end
            else
            begin
                upd.idx = st.idx + IDX_W'(1);
            end
        end
        upd.status = chk;
    end

    always_comb
    begin
        jpv_state_t fin;
        fin = (st.status == ST_OK) ? upd : st;
        res_status = fin.status;
        res_length = (fin.status == ST_OK) ? LEN_W'(fin.idx) : '0;
        st_next    = last ? STATE_CLEAR : fin;
    end

endmodule

### hdl/jailed_path_validator.sv
// jailed_path_validator: top level with input register, path state and result register
// depends on jpv_pkg, jpv_if and jpv_step
//
// usage
//   path:   one path byte per word with a last flag; a path ends on the word with last set
//   result: one word per path (status 0 ok, 1 denied, 2 no space, plus path_length when ok)
//   cfg:    register writes (0 prefix_text, 1 prefix_length, 2 max_length), always ready;
//           write only while no path is in flight and no result is pending
//   throughput: one byte per cycle; the per-path state update is one combinational step
//     between the input register and the state/result registers
//   order: an accepted last byte passes the input register, then the result register
//   stall: the result register holds while result.ready is low; bytes that do not end a
//     path keep flowing, a last byte waits in the input register until the result
//     register frees, and path.ready drops only then
//   reset: clears the pipeline valids and path state; prefix empty, max_length 256
module jailed_path_validator
    import jpv_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    jpv_path_if.sink        path,
    jpv_result_if.source    result,
    jpv_cfg_if.sink         cfg
);

    jpv_cfg_t   cfg_reg;
    jpv_state_t st_reg;
    jpv_state_t st_next;

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;

    logic             out_valid_reg;
    logic [1:0]       out_status_reg;
    logic [LEN_W-1:0] out_length_reg;

    logic             out_free;
    logic             s1_adv;
    logic             path_acc;
    logic [1:0]       res_status;
    logic [LEN_W-1:0] res_length;

    assign out_free   = !out_valid_reg || result.ready;
    assign s1_adv     = s1_valid_reg && (!s1_last_reg || out_free);
    assign path.ready = !s1_valid_reg || s1_adv;
    assign path_acc   = path.valid && path.ready;
    assign cfg.ready  = 1'b1;

    assign result.valid       = out_valid_reg;
    assign result.status      = out_status_reg;
    assign result.path_length = out_length_reg;

    jpv_step u_step (
        .cfg_val    (cfg_reg),
        .st         (st_reg),
        .c          (s1_byte_reg),
        .last       (s1_last_reg),
        .st_next    (st_next),
        .res_status (res_status),
        .res_length (res_length)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prefix_text   <= '0;
            cfg_reg.prefix_length <= '0;
            cfg_reg.max_length    <= MAXLEN_W'(256);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_PREFIX_TEXT:   cfg_reg.prefix_text   <= cfg.data;
                REG_PREFIX_LENGTH: cfg_reg.prefix_length <= cfg.data[PLEN_W-1:0];
                REG_MAX_LENGTH:    cfg_reg.max_length    <= cfg.data[MAXLEN_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= STATE_CLEAR;
        end
        else
        begin
            if (path_acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                st_reg <= st_next;
            end

            if (s1_adv && s1_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (path_acc)
        begin
            s1_byte_reg <= path.path_byte;
            s1_last_reg <= path.last;
        end
        if (s1_adv && s1_last_reg)
        begin
            out_status_reg <= res_status;
            out_length_reg <= res_length;
        end
    end

`ifndef SYNTHESIS
    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && s1_last_reg |=> result.valid)
        else $error("last byte did not produce a result");

    a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv && s1_last_reg |=> (st_reg.idx == '0) && (st_reg.status == ST_OK)
            && st_reg.pmatch)
        else $error("path state not cleared after last byte");

    a_fail_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.status != ST_OK) |-> result.path_length == '0)
        else $error("nonzero length on failed path");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.status == ST_OK) || (result.status == ST_DENIED)
            || (result.status == ST_NOSPC))
        else $error("undefined status code");
`endif

endmodule
